// ===== src/jasf_pkg.sv =====
// ----------------------------------------------------------------------------
// jasf_pkg: shared definitions for the JPEG application segment finder
// Field widths, register indexes, marker codes and result status codes.
// ----------------------------------------------------------------------------
package jasf_pkg;

    // Field widths
    localparam int BYTE_W    = 8;
    localparam int FSIZE_W   = 32;
    localparam int MAGIC_W   = 64;
    localparam int MLEN_W    = 4;
    localparam int STATUS_W  = 2;
    localparam int OFFSET_W  = 32;
    localparam int PLEN_W    = 16;
    localparam int SPAN_W    = 17;
    // Wide enough for segment start plus marker, length and 64K payload
    localparam int ADDR_W    = 34;

    // Signature compare depth and the width of a signature byte index
    localparam int MAX_MAGIC = 8;
    localparam int CMP_W     = $clog2(MAX_MAGIC);

    // Packed result: status, offset, length, zero fill to whole bytes
    localparam int RESULT_W  = STATUS_W + OFFSET_W + PLEN_W;
    localparam int M_TDATA_W = ((RESULT_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FILE_SIZE     = 2'd0,
        REG_WANTED_MARKER = 2'd1,
        REG_MAGIC_BYTES   = 2'd2,
        REG_MAGIC_LENGTH  = 2'd3
    } cfg_reg_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 2'd0,
        ST_EOI       = 2'd1,
        ST_MALFORMED = 2'd2
    } status_t;

    // Marker codes
    localparam logic [BYTE_W-1:0] MARK_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0] MARK_SOI    = 8'hD8;
    localparam logic [BYTE_W-1:0] MARK_EOI    = 8'hD9;
    localparam logic [BYTE_W-1:0] MARK_APP2   = 8'hE2;

endpackage

// ===== src/jpeg_app_segment_finder_core.sv =====
// ----------------------------------------------------------------------------
// jpeg_app_segment_finder_core: streaming JPEG marker segment walker
// Scans a JPEG file byte by byte and reports where the configured
// application segment's payload sits, or why the search ended.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one file byte per transaction in s_tdata, s_tuser
//   high on the byte at offset zero; that byte restarts the search.
//   Result channel (m_*): one transaction per file when the search ends:
//   status (found, EOI reached, malformed/out of bounds), payload offset
//   and payload length. Bytes after a result are consumed and dropped
//   until the next s_tuser byte.
//   Configuration: file size, wanted marker, signature bytes and signature
//   length are written through cfg_wr_en/cfg_addr/cfg_wdata between files.
// Timing:
//   One byte per cycle sustained. The state update and the bounds compare
//   (a 34-bit add and compare) sit between the state registers and the
//   result register, so a result shows in the cycle after its byte.
//   When the receiver stalls while a result is held, s_tready drops and
//   the input waits until that result is taken.
// Reset:
//   aresetn (synchronous, active low) restores the register defaults and
//   parks the walker idle until the first s_tuser byte.
// ----------------------------------------------------------------------------
module jpeg_app_segment_finder_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [jasf_pkg::BYTE_W-1:0]        s_tdata,   // [7:0] file_byte
    input  logic                               s_tuser,   // [0] first_of_file
    // Result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [1:0] search_status, [33:2] payload_offset, [49:34] payload_length,
    // [55:50] zero
    output logic [jasf_pkg::M_TDATA_W-1:0]     m_tdata,
    // Configuration writes
    input  logic                               cfg_wr_en,
    input  logic [jasf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [jasf_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import jasf_pkg::*;

    typedef enum logic [2:0] {
        PH_PREFIX = 3'd0,
        PH_MARKER = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_MAGIC  = 3'd4,
        PH_SKIP   = 3'd5
    } phase_t;

    // Configuration registers
    logic [FSIZE_W-1:0]   file_size_reg;
    logic [BYTE_W-1:0]    wanted_marker_reg;
    logic [MAGIC_W-1:0]   magic_bytes_reg;
    logic [MLEN_W-1:0]    magic_length_reg;

    // Walker state
    phase_t               phase_reg, phase_next;
    logic [FSIZE_W-1:0]   pos_reg, pos_next;
    logic [FSIZE_W-1:0]   seg_reg, seg_next;
    logic [BYTE_W-1:0]    marker_reg, marker_next;
    logic [SPAN_W-1:0]    span_reg, span_next;
    logic [MLEN_W-1:0]    cmp_reg, cmp_next;
    logic                 done_reg, done_next;

    // Result register
    logic                 m_valid_reg;
    status_t              status_reg, status_next;
    logic [OFFSET_W-1:0]  offset_reg, offset_next;
    logic [PLEN_W-1:0]    plen_reg, plen_next;
    logic                 report;

    // Working values
    logic                 accept;
    logic                 first;
    phase_t               cur_phase;
    logic [FSIZE_W-1:0]   cur_seg;
    logic [SPAN_W-1:0]    cur_span;
    logic [MLEN_W-1:0]    cur_cmp;
    logic [ADDR_W-1:0]    seg_x;
    logic [ADDR_W-1:0]    fsize_x;
    logic [ADDR_W-1:0]    pos1_x;
    logic [ADDR_W-1:0]    next_start;
    logic [ADDR_W-1:0]    adv_span;
    logic                 adv_fail;
    logic [PLEN_W-1:0]    seg_len;
    logic [MLEN_W-1:0]    mlen_eff;
    logic [CMP_W-1:0]     k;
    logic [BYTE_W-1:0]    expect_byte;
    logic [MLEN_W-1:0]    k_plus1;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign first    = s_tuser;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RESULT_W){1'b0}}, plen_reg, offset_reg, status_reg};

    // Take the state as it stands after a possible restart
    always_comb begin
        cur_phase = first ? PH_PREFIX : phase_reg;
        cur_seg   = first ? '0 : seg_reg;
        cur_span  = first ? '0 : span_reg;
        cur_cmp   = first ? '0 : cmp_reg;
        if (first) begin
            pos_next = '0;
        end else if (pos_reg == {FSIZE_W{1'b1}}) begin
            pos_next = pos_reg;
        end else begin
            pos_next = pos_reg + FSIZE_W'(1);
        end
    end

    // Segment arithmetic
    always_comb begin
        seg_x    = {{(ADDR_W-FSIZE_W){1'b0}}, cur_seg};
        fsize_x  = {{(ADDR_W-FSIZE_W){1'b0}}, file_size_reg};
        pos1_x   = {{(ADDR_W-FSIZE_W){1'b0}}, pos_next} + ADDR_W'(1);
        seg_len  = {cur_span[PLEN_W-1:BYTE_W], s_tdata};
        mlen_eff = (magic_length_reg > MLEN_W'(MAX_MAGIC)) ? MLEN_W'(MAX_MAGIC)
                                                           : magic_length_reg;
        k           = cur_cmp[CMP_W-1:0];
        expect_byte = magic_bytes_reg[BYTE_W*k +: BYTE_W];
        k_plus1     = {{(MLEN_W-CMP_W){1'b0}}, k} + MLEN_W'(1);
        // Start of the following segment, by phase
        unique case (cur_phase)
            PH_MARKER: next_start = seg_x + ADDR_W'(2);
            PH_LEN_LO: next_start = seg_x + ADDR_W'(2) + {{(ADDR_W-PLEN_W){1'b0}}, seg_len};
            PH_MAGIC:  next_start = seg_x + ADDR_W'(4) + {{(ADDR_W-SPAN_W){1'b0}}, cur_span};
            default:   next_start = seg_x;
        endcase
        adv_fail = (next_start + ADDR_W'(2) > fsize_x) || (next_start < pos1_x);
        adv_span = next_start - pos1_x;
    end

    // Walk one byte
    always_comb begin
        phase_next  = cur_phase;
        seg_next    = cur_seg;
        span_next   = cur_span;
        cmp_next    = cur_cmp;
        marker_next = first ? '0 : marker_reg;
        done_next   = first ? 1'b0 : done_reg;
        report      = 1'b0;
        status_next = ST_MALFORMED;
        offset_next = '0;
        plen_next   = '0;

        if (first && file_size_reg < FSIZE_W'(2)) begin
            report = 1'b1;
        end else if (first || !done_reg) begin
            unique case (cur_phase)
                PH_PREFIX: begin
                    if (s_tdata != MARK_PREFIX) begin
                        report = 1'b1;
                    end else begin
                        phase_next = PH_MARKER;
                    end
                end
                PH_MARKER: begin
                    marker_next = s_tdata;
                    if (s_tdata == MARK_EOI) begin
                        report      = 1'b1;
                        status_next = ST_EOI;
                    end else if (s_tdata == MARK_SOI) begin
                        if (adv_fail) begin
                            report = 1'b1;
                        end else begin
                            seg_next   = next_start[FSIZE_W-1:0];
                            span_next  = adv_span[SPAN_W-1:0];
                            phase_next = (adv_span == '0) ? PH_PREFIX : PH_SKIP;
                        end
                    end else if (seg_x + ADDR_W'(4) > fsize_x) begin
                        report = 1'b1;
                    end else begin
                        phase_next = PH_LEN_HI;
                    end
                end
                PH_LEN_HI: begin
                    span_next  = {1'b0, s_tdata, {BYTE_W{1'b0}}};
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (seg_len < PLEN_W'(2)) begin
                        report = 1'b1;
                    end else if (marker_reg == wanted_marker_reg && next_start <= fsize_x &&
                                 {1'b0, seg_len} >=
                                 (PLEN_W+1)'(2) + {{(PLEN_W+1-MLEN_W){1'b0}}, mlen_eff}) begin
                        if (mlen_eff == '0) begin
                            report      = 1'b1;
                            status_next = ST_FOUND;
                            offset_next = cur_seg + OFFSET_W'(4);
                            plen_next   = seg_len - PLEN_W'(2);
                        end else begin
                            span_next  = {1'b0, seg_len - PLEN_W'(2)};
                            cmp_next   = '0;
                            phase_next = PH_MAGIC;
                        end
                    end else if (adv_fail) begin
                        report = 1'b1;
                    end else begin
                        seg_next   = next_start[FSIZE_W-1:0];
                        span_next  = adv_span[SPAN_W-1:0];
                        phase_next = (adv_span == '0) ? PH_PREFIX : PH_SKIP;
                    end
                end
                PH_MAGIC: begin
                    if (s_tdata != expect_byte) begin
                        if (adv_fail) begin
                            report = 1'b1;
                        end else begin
                            seg_next   = next_start[FSIZE_W-1:0];
                            span_next  = adv_span[SPAN_W-1:0];
                            phase_next = (adv_span == '0) ? PH_PREFIX : PH_SKIP;
                        end
                    end else if (k_plus1 >= mlen_eff) begin
                        report      = 1'b1;
                        status_next = ST_FOUND;
                        offset_next = cur_seg + OFFSET_W'(4);
                        plen_next   = cur_span[PLEN_W-1:0];
                    end else begin
                        cmp_next = k_plus1;
                    end
                end
                PH_SKIP: begin
                    if (cur_span > SPAN_W'(1)) begin
                        span_next = cur_span - SPAN_W'(1);
                    end else begin
                        span_next  = '0;
                        phase_next = PH_PREFIX;
                    end
                end
                default: begin
                    report = 1'b1;
                end
            endcase
        end
        if (report) begin
            done_next = 1'b1;
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_size_reg     <= '0;
            wanted_marker_reg <= MARK_APP2;
            magic_bytes_reg   <= '0;
            magic_length_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_FILE_SIZE:     file_size_reg     <= cfg_wdata[FSIZE_W-1:0];
                REG_WANTED_MARKER: wanted_marker_reg <= cfg_wdata[BYTE_W-1:0];
                REG_MAGIC_BYTES:   magic_bytes_reg   <= cfg_wdata[MAGIC_W-1:0];
                REG_MAGIC_LENGTH:  magic_length_reg  <= cfg_wdata[MLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Walker state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_PREFIX;
            pos_reg     <= '0;
            seg_reg     <= '0;
            marker_reg  <= '0;
            span_reg    <= '0;
            cmp_reg     <= '0;
            done_reg    <= 1'b1;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg  <= phase_next;
                pos_reg    <= pos_next;
                seg_reg    <= seg_next;
                marker_reg <= marker_next;
                span_reg   <= span_next;
                cmp_reg    <= cmp_next;
                done_reg   <= done_next;
            end
            // Load a new result, or drop the one just taken
            if (accept && report) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (accept && report) begin
            status_reg <= status_next;
            offset_reg <= offset_next;
            plen_reg   <= plen_next;
        end
    end

endmodule
